/* hw/rtl/disk_arm_seek_scheduler_core_assert.svh */
// assertion macros for the disk arm seek scheduler
`ifndef DISK_ARM_SEEK_SCHEDULER_CORE_ASSERT_SVH
`define DISK_ARM_SEEK_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define DASC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dasc assertion failed");

// next-cycle implication
`define DASC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dasc assertion failed");

`endif

/* hw/rtl/dasc_pkg.sv */
// types, constants and step table of the disk arm seek scheduler
package dasc_pkg;

  localparam int CYL_W = 12;
  localparam int MOV_W = 20;
  localparam int CC_W = 13;
  localparam int POL_W = 3;
  localparam int PH_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_REQUESTS_DEF = 32;
  localparam logic [MOV_W-1:0] MOVE_MAX = {MOV_W{1'b1}};
  localparam logic [CC_W-1:0] CC_MIN = CC_W'(2);
  localparam logic [CC_W-1:0] CC_MAX = CC_W'(1 << CYL_W);

  localparam logic [POL_W-1:0] POL_FCFS  = 3'd0;
  localparam logic [POL_W-1:0] POL_SSTF  = 3'd1;
  localparam logic [POL_W-1:0] POL_SCAN  = 3'd2;
  localparam logic [POL_W-1:0] POL_CSCAN = 3'd3;
  localparam logic [POL_W-1:0] POL_LOOK  = 3'd4;
  localparam logic [POL_W-1:0] POL_CLOOK = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CCOUNT = 2'd3;

  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             last_request;
  } in_t;

  typedef struct packed {
    logic [CYL_W-1:0] served_cylinder;
    logic [MOV_W-1:0] movement_so_far;
    logic             last_served;
  } out_t;

  typedef enum logic [2:0] {
    S_LOAD, S_START, S_STEP, S_SCAN, S_PICK, S_FLUSH
  } state_t;

  typedef enum logic [1:0] {K_SWEEP, K_MOVE, K_END} kind_t;
  typedef enum logic [1:0] {SEL_FCFS, SEL_SSTF, SEL_ASC, SEL_DESC} sel_t;
  typedef enum logic [2:0] {R_ALL, R_GE, R_LT, R_LE, R_GT} rng_t;

  typedef struct packed {
    kind_t kind;
    sel_t  sel;
    rng_t  rng;
    logic  to_top;
  } step_t;

  function automatic step_t step_of(input logic [POL_W-1:0] pol, input logic up,
                                    input logic [PH_W-1:0] ph);
    step_t st;
    st.kind = K_END;
    st.sel = SEL_ASC;
    st.rng = R_ALL;
    st.to_top = 1'b0;
    if (ph == PH_W'(0) && (pol == POL_SCAN || pol == POL_CSCAN ||
                           pol == POL_LOOK || pol == POL_CLOOK)) begin
      st.kind = K_SWEEP;
      st.sel = up ? SEL_ASC : SEL_DESC;
      st.rng = up ? R_GE : R_LE;
    end else begin
      case (pol)
        POL_SSTF: begin
          if (ph == PH_W'(0)) begin
            st.kind = K_SWEEP;
            st.sel = SEL_SSTF;
          end
        end
        POL_SCAN: begin
          if (ph == PH_W'(1)) begin
            st.kind = K_MOVE;
            st.to_top = up;
          end else if (ph == PH_W'(2)) begin
            st.kind = K_SWEEP;
            st.sel = up ? SEL_DESC : SEL_ASC;
            st.rng = up ? R_LT : R_GT;
          end
        end
        POL_CSCAN: begin
          if (ph == PH_W'(1) || ph == PH_W'(2)) begin
            st.kind = K_MOVE;
            st.to_top = (ph == PH_W'(1)) ? up : !up;
          end else if (ph == PH_W'(3)) begin
            st.kind = K_SWEEP;
            st.sel = up ? SEL_ASC : SEL_DESC;
            st.rng = up ? R_LT : R_GT;
          end
        end
        POL_LOOK: begin
          if (ph == PH_W'(1)) begin
            st.kind = K_SWEEP;
            st.sel = up ? SEL_DESC : SEL_ASC;
            st.rng = up ? R_LT : R_GT;
          end
        end
        POL_CLOOK: begin
          if (ph == PH_W'(1)) begin
            st.kind = K_SWEEP;
            st.sel = up ? SEL_ASC : SEL_DESC;
            st.rng = up ? R_LT : R_GT;
          end
        end
        default: begin
          if (ph == PH_W'(0)) begin
            st.kind = K_SWEEP;
            st.sel = SEL_FCFS;
          end
        end
      endcase
    end
    return st;
  endfunction

  // saturating add of the distance between two cylinders
  function automatic logic [MOV_W-1:0] mov_add(input logic [MOV_W-1:0] m,
                                               input logic [CYL_W-1:0] a,
                                               input logic [CYL_W-1:0] b);
    logic [CYL_W-1:0] d;
    logic [MOV_W:0] s;
    d = (a > b) ? (a - b) : (b - a);
    s = {1'b0, m} + (MOV_W + 1)'(d);
    return s[MOV_W] ? MOVE_MAX : s[MOV_W-1:0];
  endfunction

endpackage

/* hw/rtl/disk_arm_seek_scheduler_core.sv */
// disk arm seek scheduler: request store, sweep sequencer and result register
//
//   channel  direction  payload        transfer when
//   in       sink       dasc_pkg::in_t  in_valid && in_ready
//   out      source     dasc_pkg::out_t out_valid && out_ready
//   cfg      sink       index, data     cfg_valid && cfg_ready
//
// loading takes one cycle per request; the batch is scheduled after the last one
// each result takes a step state, one read of the single request memory port per
// entry, the drain of the registered read data, and a pick state
// each sweep ends with one scan that finds no candidate; each end-of-stroke or wrap
// move is made in a step state; a batch also passes the start state, end step and flush
// no requests are taken while a batch is scheduled; out stalls hold the sequencer
// reset empties the batch and loads the register defaults
module disk_arm_seek_scheduler_core #(
  parameter int MAX_REQUESTS = dasc_pkg::MAX_REQUESTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  dasc_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output dasc_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dasc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dasc_pkg::CC_W-1:0]          cfg_data
);

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  dasc_pkg::state_t state, state_next;

  logic [dasc_pkg::POL_W-1:0] policy_mode;
  logic [dasc_pkg::CYL_W-1:0] start_position;
  logic                       start_direction;
  logic [dasc_pkg::CC_W-1:0]  cylinder_count;

  logic [dasc_pkg::CYL_W-1:0] mem [MAX_REQUESTS];
  logic [dasc_pkg::CYL_W-1:0] mem_q;

  logic [CNT_W-1:0]           cnt;
  logic [MAX_REQUESTS-1:0]    served;
  logic [dasc_pkg::CYL_W-1:0] head;
  logic [dasc_pkg::MOV_W-1:0] mov;
  logic [dasc_pkg::PH_W-1:0]  ph;
  logic [CNT_W-1:0]           rd_idx;
  logic                       rd_v;
  logic [IDX_W-1:0]           rd_i;
  logic                       found;
  logic [IDX_W-1:0]           best_idx;
  logic [dasc_pkg::CYL_W-1:0] best_v;
  logic [dasc_pkg::CYL_W-1:0] best_d;
  logic                       pend_valid;
  logic [dasc_pkg::CYL_W-1:0] pend_cyl;
  logic [dasc_pkg::MOV_W-1:0] pend_mov;

  logic [dasc_pkg::CC_W-1:0]  cc_c;
  logic [dasc_pkg::CYL_W-1:0] top;
  logic [dasc_pkg::CYL_W-1:0] s_pos;
  logic [dasc_pkg::CYL_W-1:0] in_cyl;
  dasc_pkg::step_t            st;
  logic [dasc_pkg::CYL_W-1:0] cand_d;
  logic                       rng_ok;
  logic                       better;
  logic                       cand;
  logic                       scan_done;
  logic                       out_free;
  logic                       in_xfer;
  logic                       issue;
  logic                       emit;

  assign cc_c = (cylinder_count < dasc_pkg::CC_MIN) ? dasc_pkg::CC_MIN :
                (cylinder_count > dasc_pkg::CC_MAX) ? dasc_pkg::CC_MAX : cylinder_count;
  assign top = dasc_pkg::CYL_W'(cc_c - dasc_pkg::CC_W'(1));
  assign s_pos = (start_position > top) ? top : start_position;
  assign in_cyl = (in_data.request_cylinder > top) ? top : in_data.request_cylinder;
  assign st = dasc_pkg::step_of(policy_mode, start_direction, ph);
  assign in_xfer = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign scan_done = (rd_idx == cnt) && !rd_v;
  assign cfg_ready = 1'b1;

  always_comb begin
    case (st.rng)
      dasc_pkg::R_GE: rng_ok = mem_q >= s_pos;
      dasc_pkg::R_LT: rng_ok = mem_q < s_pos;
      dasc_pkg::R_LE: rng_ok = mem_q <= s_pos;
      dasc_pkg::R_GT: rng_ok = mem_q > s_pos;
      default:        rng_ok = 1'b1;
    endcase
  end

  assign cand_d = (mem_q > head) ? (mem_q - head) : (head - mem_q);

  always_comb begin
    case (st.sel)
      dasc_pkg::SEL_SSTF: better = !found || (cand_d < best_d);
      dasc_pkg::SEL_ASC:  better = !found || (mem_q < best_v);
      dasc_pkg::SEL_DESC: better = !found || (mem_q >= best_v);
      default:            better = !found;
    endcase
  end

  assign cand = rd_v && !served[rd_i] && rng_ok && better;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dasc_pkg::S_LOAD: begin
        if (in_xfer && in_data.last_request) state_next = dasc_pkg::S_START;
      end
      dasc_pkg::S_START: state_next = dasc_pkg::S_STEP;
      dasc_pkg::S_STEP: begin
        case (st.kind)
          dasc_pkg::K_SWEEP: state_next = dasc_pkg::S_SCAN;
          dasc_pkg::K_MOVE:  state_next = dasc_pkg::S_STEP;
          default:           state_next = dasc_pkg::S_FLUSH;
        endcase
      end
      dasc_pkg::S_SCAN: begin
        if (scan_done) state_next = dasc_pkg::S_PICK;
      end
      dasc_pkg::S_PICK: begin
        if (!found || out_free) state_next = dasc_pkg::S_STEP;
      end
      dasc_pkg::S_FLUSH: begin
        if (out_free) state_next = dasc_pkg::S_LOAD;
      end
      default: state_next = dasc_pkg::S_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state == dasc_pkg::S_LOAD);
    issue = (state == dasc_pkg::S_SCAN) && (rd_idx != cnt);
    emit = out_free && pend_valid &&
           ((state == dasc_pkg::S_PICK && found) || (state == dasc_pkg::S_FLUSH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dasc_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= dasc_pkg::POL_FCFS;
      start_position <= '0;
      start_direction <= 1'b1;
      cylinder_count <= dasc_pkg::CC_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dasc_pkg::REG_POLICY: policy_mode <= cfg_data[dasc_pkg::POL_W-1:0];
        dasc_pkg::REG_START:  start_position <= cfg_data[dasc_pkg::CYL_W-1:0];
        dasc_pkg::REG_DIR:    start_direction <= cfg_data[0];
        dasc_pkg::REG_CCOUNT: cylinder_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // request memory
  always_ff @(posedge clk) begin
    if (in_xfer && cnt < CNT_MAX) mem[cnt[IDX_W-1:0]] <= in_cyl;
    mem_q <= mem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      served <= '0;
      head <= '0;
      mov <= '0;
      ph <= '0;
      rd_idx <= '0;
      rd_v <= 1'b0;
      found <= 1'b0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      rd_v <= issue;
      case (state)
        dasc_pkg::S_LOAD: begin
          if (in_xfer && cnt < CNT_MAX) cnt <= cnt + CNT_W'(1);
        end
        dasc_pkg::S_START: begin
          head <= s_pos;
          mov <= '0;
          ph <= '0;
          pend_valid <= 1'b0;
        end
        dasc_pkg::S_STEP: begin
          rd_idx <= '0;
          found <= 1'b0;
          if (st.kind == dasc_pkg::K_MOVE) begin
            mov <= dasc_pkg::mov_add(mov, head, st.to_top ? top : '0);
            head <= st.to_top ? top : '0;
            ph <= ph + dasc_pkg::PH_W'(1);
          end
        end
        dasc_pkg::S_SCAN: begin
          if (issue) rd_idx <= rd_idx + CNT_W'(1);
          if (cand) begin
            found <= 1'b1;
            best_idx <= rd_i;
            best_v <= mem_q;
            best_d <= cand_d;
          end
        end
        dasc_pkg::S_PICK: begin
          if (!found) begin
            ph <= ph + dasc_pkg::PH_W'(1);
          end else if (out_free) begin
            if (pend_valid) begin
              out_data.served_cylinder <= pend_cyl;
              out_data.movement_so_far <= pend_mov;
              out_data.last_served <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_cyl <= best_v;
            pend_mov <= dasc_pkg::mov_add(mov, head, best_v);
            mov <= dasc_pkg::mov_add(mov, head, best_v);
            head <= best_v;
            served[best_idx] <= 1'b1;
          end
        end
        dasc_pkg::S_FLUSH: begin
          if (out_free) begin
            if (pend_valid) begin
              out_data.served_cylinder <= pend_cyl;
              out_data.movement_so_far <= mov;
              out_data.last_served <= 1'b1;
            end
            pend_valid <= 1'b0;
            served <= '0;
            cnt <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_i <= rd_idx[IDX_W-1:0];
  end

`include "disk_arm_seek_scheduler_core_assert.svh"

  `DASC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CNT_MAX)
  `DASC_ASSERT_NOW(a_load_only_last, state == dasc_pkg::S_LOAD && out_valid,
                   out_data.last_served)
  `DASC_ASSERT_NEXT(a_flush_last, state == dasc_pkg::S_FLUSH && out_free && pend_valid,
                    out_valid && out_data.last_served && state == dasc_pkg::S_LOAD)
  `DASC_ASSERT_NEXT(a_pick_marks, state == dasc_pkg::S_PICK && found && out_free,
                    served[$past(best_idx)] && pend_valid)

endmodule
